@@ design/nvtks_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nvtks_pkg
// shared widths, codes and types of the nearest vector top-k selector
// ----------------------------------------------------------------------------
package nvtks_pkg;

   localparam int OP_W       = 2;
   localparam int VAL_W      = 16;
   localparam int ID_W       = 32;
   localparam int DIST_W     = 45;
   localparam int SQ_W       = 32;
   localparam int KCNT_W     = 5;
   localparam int VDIM_W     = 11;
   localparam int CSR_W      = 11;
   localparam int CSR_IDX_W  = 1;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 80;
   localparam int RSP_PAD_W  = RSP_DATA_W - DIST_W - ID_W;

   localparam logic [OP_W-1:0] OP_QUERY  = 2'd0;
   localparam logic [OP_W-1:0] OP_CAND   = 2'd1;
   localparam logic [OP_W-1:0] OP_FINISH = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_K_COUNT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_VEC_DIM = 1'd1;

   localparam logic [KCNT_W-1:0] K_COUNT_RESET = 5'd10;
   localparam logic [VDIM_W-1:0] VEC_DIM_RESET = 11'd128;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic [ID_W-1:0]   id;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type cand;
   } offer_type;

   typedef struct packed {
      logic      ins;
      logic      pop;
      entry_type cand;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_RUN,
      ST_DRAIN,
      ST_EMIT
   } state_type;

endpackage
`default_nettype wire

@@ design/nvtks_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nvtks_cell
// one slot of the sorted neighbor list, shifts right on insert, left on pop
// ----------------------------------------------------------------------------
module nvtks_cell (
   input  wire                      clock,
   input  nvtks_pkg::cell_ctrl_type ctrl,
   input  wire                      live,
   input  wire                      left_ahead,
   input  nvtks_pkg::entry_type     left_entry,
   input  nvtks_pkg::entry_type     right_entry,
   output nvtks_pkg::entry_type     entry,
   output logic                     ahead,
   output logic                     closer
);
   import nvtks_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // slot stays ahead of the candidate: nearer, or equal with smaller-or-equal id
   assign ahead  = live && ((entry_ff.distance < ctrl.cand.distance) ||
                            ((entry_ff.distance == ctrl.cand.distance) &&
                             (entry_ff.id <= ctrl.cand.id)));
   assign closer = ctrl.cand.distance < entry_ff.distance;
   assign entry  = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      priority if (ctrl.pop) begin
         entry_in = right_entry;
      end else if (ctrl.ins && !ahead) begin
         entry_in = left_ahead ? ctrl.cand : left_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule
`default_nettype wire

@@ design/nvtks_dist.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nvtks_dist
// query store and pipelined squared distance accumulator
// ----------------------------------------------------------------------------
module nvtks_dist #(
   parameter int DIM_MAX = 1024,
   parameter int IDX_W   = 10
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          in_valid,
   input  wire                          in_query,
   input  wire                          in_last,
   input  wire [IDX_W-1:0]              in_idx,
   input  wire [nvtks_pkg::VAL_W-1:0]   in_value,
   input  wire [nvtks_pkg::ID_W-1:0]    in_id,
   input  wire                          clear_acc,
   output nvtks_pkg::offer_type         offer,
   output logic                         busy
);
   import nvtks_pkg::*;

   logic signed [VAL_W-1:0] query_mem [DIM_MAX];

   logic signed [VAL_W-1:0] q_rd_ff;
   logic                    a_valid_ff;
   logic                    a_last_ff;
   logic signed [VAL_W-1:0] a_val_ff;
   logic [ID_W-1:0]         a_id_ff;

   logic                    b_valid_ff;
   logic                    b_last_ff;
   logic [ID_W-1:0]         b_id_ff;
   logic [SQ_W-1:0]         sq_ff;
   logic [SQ_W-1:0]         sq_in;

   logic [DIST_W-1:0]       acc_ff;
   logic [DIST_W-1:0]       acc_in;
   logic [DIST_W:0]         sum;
   logic [DIST_W-1:0]       sum_sat;
   offer_type               offer_ff;
   offer_type               offer_in;

   logic signed [VAL_W:0]   diff;
   logic signed [2*VAL_W+1:0] prod;

   always_ff @(posedge clock) begin
      if (in_valid) begin
         if (in_query) begin
            query_mem[in_idx] <= in_value;
         end
         q_rd_ff <= query_mem[in_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid && !in_query;
      end
      a_last_ff <= in_last;
      a_val_ff  <= in_value;
      a_id_ff   <= in_id;
   end

   assign diff  = {a_val_ff[VAL_W-1], a_val_ff} - {q_rd_ff[VAL_W-1], q_rd_ff};
   assign prod  = diff * diff;
   assign sq_in = prod[SQ_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
      b_last_ff <= a_last_ff;
      b_id_ff   <= a_id_ff;
      sq_ff     <= sq_in;
   end

   assign sum     = {1'b0, acc_ff} + {{(DIST_W + 1 - SQ_W){1'b0}}, sq_ff};
   assign sum_sat = sum[DIST_W] ? {DIST_W{1'b1}} : sum[DIST_W-1:0];

   always_comb begin
      acc_in         = acc_ff;
      offer_in.valid = 1'b0;
      offer_in.cand.distance = sum_sat;
      offer_in.cand.id       = b_id_ff;
      priority if (clear_acc) begin
         acc_in = '0;
      end else if (b_valid_ff && b_last_ff) begin
         acc_in         = '0;
         offer_in.valid = 1'b1;
      end else if (b_valid_ff) begin
         acc_in = sum_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff         <= '0;
         offer_ff.valid <= 1'b0;
      end else begin
         acc_ff         <= acc_in;
         offer_ff.valid <= offer_in.valid;
      end
      offer_ff.cand <= offer_in.cand;
   end

   assign offer = offer_ff;
   assign busy  = a_valid_ff || b_valid_ff || offer_ff.valid;

endmodule
`default_nettype wire

@@ design/nearest_vector_top_k_select.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_vector_top_k_select
// brute-force k nearest neighbor selector over squared l2 distance
// ----------------------------------------------------------------------------
// throughput: one query or candidate element per cycle in the run state, set by the
//   single query memory port and one multiply-accumulate per element
// path: a candidate passes the a, b and offer registers before the sorted cell row
// finish: drain, then one result per cycle while rsp_tready allows, n results or
//   one empty marker; new items are taken again once the final result is loaded
// reset: synchronous, clears counters, accumulator, fill count and handshakes;
//   query memory and list slots keep their contents, the fill count empties the list
// ----------------------------------------------------------------------------
module nearest_vector_top_k_select #(
   parameter int K_MAX   = 16,
   parameter int DIM_MAX = 1024
) (
   input  wire                              clock,
   input  wire                              reset,
   // request stream
   input  wire                              req_tvalid,
   output logic                             req_tready,
   // tdata: elem_value[15:0], cand_id[47:16]
   input  wire [nvtks_pkg::REQ_DATA_W-1:0]  req_tdata,
   // tuser: op[1:0]
   input  wire [nvtks_pkg::OP_W-1:0]        req_tuser,
   // response stream
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   // tdata: result_distance[44:0], result_id[76:45], zero pad above
   output logic [nvtks_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // tuser: result_valid[0]
   output logic [0:0]                       rsp_tuser,
   output logic                             rsp_tlast,
   // register writes
   input  wire                              csr_we,
   input  wire [nvtks_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire [nvtks_pkg::CSR_W-1:0]       csr_wdata
);
   import nvtks_pkg::*;

   localparam int IDX_W   = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
   localparam int DLIM_W  = $clog2(DIM_MAX + 1);
   localparam int DCMP_W  = (DLIM_W > VDIM_W) ? DLIM_W : VDIM_W;
   localparam int K_W     = (K_MAX > 1) ? $clog2(K_MAX) : 1;
   localparam int FILL_W  = $clog2(K_MAX + 1);
   localparam int KCMP_W  = (FILL_W > KCNT_W) ? FILL_W : KCNT_W;
   localparam logic [DCMP_W-1:0] DIM_LIM = DCMP_W'(DIM_MAX);
   localparam logic [KCMP_W-1:0] K_LIM   = KCMP_W'(K_MAX);

   // configuration registers
   logic [KCNT_W-1:0] k_count_ff;
   logic [VDIM_W-1:0] vec_dim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         k_count_ff <= K_COUNT_RESET;
         vec_dim_ff <= VEC_DIM_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_K_COUNT: k_count_ff <= csr_wdata[KCNT_W-1:0];
            REG_VEC_DIM: vec_dim_ff <= csr_wdata[VDIM_W-1:0];
            default: ;
         endcase
      end
   end

   // out-of-range settings clamp to the nearest legal value
   logic [DCMP_W-1:0] vdim_w;
   logic [DCMP_W-1:0] eff_dim;
   logic [KCMP_W-1:0] kc_w;
   logic [KCMP_W-1:0] eff_k_w;
   logic [FILL_W-1:0] eff_k;

   assign vdim_w = DCMP_W'(vec_dim_ff);
   assign kc_w   = KCMP_W'(k_count_ff);

   always_comb begin
      priority if (vdim_w == '0) begin
         eff_dim = DCMP_W'(1);
      end else if (vdim_w > DIM_LIM) begin
         eff_dim = DIM_LIM;
      end else begin
         eff_dim = vdim_w;
      end
      priority if (kc_w == '0) begin
         eff_k_w = KCMP_W'(1);
      end else if (kc_w > K_LIM) begin
         eff_k_w = K_LIM;
      end else begin
         eff_k_w = kc_w;
      end
   end

   assign eff_k = eff_k_w[FILL_W-1:0];

   // request decode and shared element counter
   logic              req_xfer;
   logic [OP_W-1:0]   op;
   logic              is_elem;
   logic              is_finish;
   logic [IDX_W-1:0]  idx_ff;
   logic [IDX_W-1:0]  idx_in;
   logic [DCMP_W-1:0] idx_nxt;
   logic              vec_end;

   assign req_xfer  = req_tvalid && req_tready;
   assign op        = req_tuser;
   assign is_elem   = (op == OP_QUERY) || (op == OP_CAND);
   assign is_finish = (op == OP_FINISH);
   assign idx_nxt   = DCMP_W'(idx_ff) + DCMP_W'(1);
   // counter wraps when it reaches the dimension, also if the dimension shrank
   assign vec_end   = idx_nxt >= eff_dim;

   always_comb begin
      idx_in = idx_ff;
      priority if (req_xfer && is_finish) begin
         idx_in = '0;
      end else if (req_xfer && is_elem) begin
         idx_in = vec_end ? '0 : idx_nxt[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   // distance pipeline
   offer_type offer;
   logic      dist_busy;
   logic      clear_acc;

   nvtks_dist #(
      .DIM_MAX (DIM_MAX),
      .IDX_W   (IDX_W)
   ) u_dist (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_xfer && is_elem),
      .in_query  (op == OP_QUERY),
      .in_last   (vec_end),
      .in_idx    (idx_ff),
      .in_value  (req_tdata[VAL_W-1:0]),
      .in_id     (req_tdata[VAL_W +: ID_W]),
      .clear_acc (clear_acc),
      .offer     (offer),
      .busy      (dist_busy)
   );

   // list bookkeeping: a full list only takes a strictly nearer candidate
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;
   logic              full;
   logic [FILL_W-1:0] fill_eff;
   logic [FILL_W-1:0] k_last;
   logic              reject;
   logic [K_MAX-1:0]  closer_v;
   logic [K_MAX:0]    ahead_v;
   entry_type         ent_v [K_MAX+2];
   cell_ctrl_type     cell_ctrl;

   assign full     = fill_ff >= eff_k;
   assign fill_eff = full ? (eff_k - FILL_W'(1)) : fill_ff;
   assign k_last   = eff_k - FILL_W'(1);
   assign reject   = full && !closer_v[k_last[K_W-1:0]];

   // emit control
   state_type         state_ff;
   state_type         state_in;
   logic [FILL_W-1:0] emit_left_ff;
   logic [FILL_W-1:0] emit_left_in;
   logic              rsp_load;
   logic              rsp_pop;
   logic              drain_done;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_RUN: begin
            if (req_xfer && is_finish) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!dist_busy) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_load && (emit_left_ff <= FILL_W'(1))) begin
               state_in = ST_RUN;
            end
         end
         default: state_in = ST_RUN;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      rsp_load   = 1'b0;
      rsp_pop    = 1'b0;
      drain_done = 1'b0;
      unique case (state_ff)
         ST_RUN: begin
            req_tready = 1'b1;
         end
         ST_DRAIN: begin
            drain_done = !dist_busy;
         end
         ST_EMIT: begin
            rsp_load = !rsp_tvalid || rsp_tready;
            rsp_pop  = rsp_load && (emit_left_ff != '0);
         end
         default: ;
      endcase
   end

   // partial candidate is dropped once the pipeline is empty
   assign clear_acc = drain_done;

   assign cell_ctrl.ins  = offer.valid && !reject;
   assign cell_ctrl.pop  = rsp_pop;
   assign cell_ctrl.cand = offer.cand;

   always_comb begin
      fill_in      = fill_ff;
      emit_left_in = emit_left_ff;
      priority if (drain_done) begin
         fill_in      = '0;
         emit_left_in = full ? eff_k : fill_ff;
      end else if (rsp_pop) begin
         emit_left_in = emit_left_ff - FILL_W'(1);
      end else if (offer.valid) begin
         // a refused candidate still trims a list left longer than k
         fill_in = reject ? eff_k : (fill_eff + FILL_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         fill_ff      <= '0;
         emit_left_ff <= '0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         emit_left_ff <= emit_left_in;
      end
   end

   // sorted cell row, slot 0 holds the nearest neighbor
   // nothing sits left of slot 0, so it counts as ahead of any candidate
   assign ahead_v[0]     = 1'b1;
   assign ent_v[0]       = '0;
   assign ent_v[K_MAX+1] = '0;

   for (genvar i = 0; i < K_MAX; i++) begin : g_cell
      nvtks_cell u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl),
         .live        (FILL_W'(i) < fill_eff),
         .left_ahead  (ahead_v[i]),
         .left_entry  (ent_v[i]),
         .right_entry (ent_v[i+2]),
         .entry       (ent_v[i+1]),
         .ahead       (ahead_v[i+1]),
         .closer      (closer_v[i])
      );
   end

   // output register, parts the response side from the cell row
   logic              rsp_valid_ff;
   logic [DIST_W-1:0] rsp_dist_ff;
   logic [ID_W-1:0]   rsp_id_ff;
   logic              rsp_flag_ff;
   logic              rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         if (emit_left_ff == '0) begin
            // finish with an empty list
            rsp_dist_ff <= '0;
            rsp_id_ff   <= '0;
            rsp_flag_ff <= 1'b0;
            rsp_last_ff <= 1'b1;
         end else begin
            rsp_dist_ff <= ent_v[1].distance;
            rsp_id_ff   <= ent_v[1].id;
            rsp_flag_ff <= 1'b1;
            rsp_last_ff <= (emit_left_ff == FILL_W'(1));
         end
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {{RSP_PAD_W{1'b0}}, rsp_id_ff, rsp_dist_ff};
   assign rsp_tuser[0] = rsp_flag_ff;
   assign rsp_tlast    = rsp_last_ff;

endmodule
`default_nettype wire
